[sv/kes_pkg.sv]
package kes_pkg;

    // Field widths
    localparam int ANGLE_WIDTH     = 32;
    localparam int ANGLE_FRAC_BITS = 28;
    localparam int COUNT_WIDTH     = 10;
    localparam int ECC_WIDTH       = 31;
    localparam int TOL_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 16;

    // Internal formats
    localparam int INT_FRAC     = 60;
    localparam int WORD_WIDTH   = 64;
    localparam int HALF_WIDTH   = WORD_WIDTH / 2;
    localparam int ACC_WIDTH    = 2 * WORD_WIDTH;
    localparam int RED_WIDTH    = ANGLE_WIDTH + 2;
    localparam int DIFF_WIDTH   = ANGLE_WIDTH + 1;
    localparam int FRAC_SHIFT   = INT_FRAC - ANGLE_FRAC_BITS;
    localparam int ECC_SHIFT    = ECC_WIDTH + INT_FRAC - ANGLE_FRAC_BITS;
    localparam int TAYLOR_TERMS = 12;
    localparam int TERM_WIDTH   = $clog2(TAYLOR_TERMS);
    localparam int DIV_WIDTH    = 10;
    localparam int PP_WIDTH     = 3;

    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [RED_WIDTH-1:0]   t_red;
    typedef logic        [ECC_WIDTH-1:0]   t_ecc;
    typedef logic        [COUNT_WIDTH-1:0] t_count;
    typedef logic        [TOL_WIDTH-1:0]   t_tol;
    typedef logic        [WORD_WIDTH-1:0]  t_word;
    typedef logic        [ACC_WIDTH-1:0]   t_acc;
    typedef logic        [TERM_WIDTH-1:0]  t_term;
    typedef logic        [PP_WIDTH-1:0]    t_pp;
    typedef logic        [CFG_INDEX_WIDTH-1:0] t_cfg_index;
    typedef logic        [CFG_DATA_WIDTH-1:0]  t_cfg_data;

    // Register indexes and reset values
    localparam t_cfg_index CFG_TOLERANCE     = t_cfg_index'(0);
    localparam t_cfg_index CFG_ITERATION_CAP = t_cfg_index'(1);
    localparam t_tol       TOL_RESET         = t_tol'(268);
    localparam t_count     CAP_RESET         = t_count'(1000);

    // pi in Q.60, and pi, 2*pi rounded half up to angle precision
    localparam t_word PI_FIX   = 64'h3243F6A8885A308D;
    localparam t_word PI_HALF  = PI_FIX >> 1;
    localparam t_word PI_A     = (PI_FIX + (t_word'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
    localparam t_word TWO_PI_A =
        ((PI_FIX << 1) + (t_word'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;

    localparam t_red RED_PI      = t_red'(PI_A);
    localparam t_red RED_TWO_PI  = t_red'(TWO_PI_A);
    localparam t_red RED_LOW     = -RED_PI;
    localparam t_red RED_HIGH    = RED_TWO_PI - RED_PI;
    localparam t_red RED_ANG_MAX =
        $signed({{(RED_WIDTH-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}});
    localparam t_red RED_ANG_MIN =
        $signed({{(RED_WIDTH-ANGLE_WIDTH+1){1'b1}}, {(ANGLE_WIDTH-1){1'b0}}});

    // Rounding constants for the product accumulator
    localparam t_acc RND_Q60 = t_acc'(1) << (INT_FRAC - 1);
    localparam t_acc RND_ECC = t_acc'(1) << (ECC_SHIFT - 1);

    // Taylor divisors (2k)(2k+1) and floor(2^64 / divisor)
    localparam logic [WORD_WIDTH:0] TWO_POW_64 = {1'b1, {WORD_WIDTH{1'b0}}};

    localparam logic [DIV_WIDTH-1:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
        10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
    };

    localparam t_word TAYLOR_RECIP [TAYLOR_TERMS] = '{
        t_word'(TWO_POW_64 / 6),   t_word'(TWO_POW_64 / 20),  t_word'(TWO_POW_64 / 42),
        t_word'(TWO_POW_64 / 72),  t_word'(TWO_POW_64 / 110), t_word'(TWO_POW_64 / 156),
        t_word'(TWO_POW_64 / 210), t_word'(TWO_POW_64 / 272), t_word'(TWO_POW_64 / 342),
        t_word'(TWO_POW_64 / 420), t_word'(TWO_POW_64 / 506), t_word'(TWO_POW_64 / 600)
    };

    // Multiplier sequence: four partial products, then a drain step
    localparam t_pp PP_DRAIN = t_pp'(4);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_FOLD,
        S_MUL,
        S_SQUARE_DONE,
        S_TERM_DIV,
        S_TERM_REM,
        S_TERM_FIX,
        S_TERM_ACC,
        S_UPDATE,
        S_CHECK,
        S_DONE
    } t_kes_state;

endpackage

[sv/kes_if.sv]
interface kes_in_if;
    import kes_pkg::*;

    logic   valid;
    logic   ready;
    t_angle mean_anomaly;
    t_ecc   eccentricity;

    modport source (output valid, output mean_anomaly, output eccentricity, input ready);
    modport sink   (input valid, input mean_anomaly, input eccentricity, output ready);
endinterface

interface kes_out_if;
    import kes_pkg::*;

    logic   valid;
    logic   ready;
    t_angle eccentric_anomaly;
    t_count iterations_done;
    logic   not_converged;

    modport source (output valid, output eccentric_anomaly, output iterations_done,
                    output not_converged, input ready);
    modport sink   (input valid, input eccentric_anomaly, input iterations_done,
                    input not_converged, output ready);
endinterface

interface kes_cfg_if;
    import kes_pkg::*;

    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/kepler_equation_solver.sv]
// Kepler equation solver: E = M + e*sin(E) by fixed-point iteration.
//
// Channels: i_in takes one item (mean anomaly Q3.28, eccentricity Q0.31);
// o_out returns one item per input (last estimate, iteration count,
// not-converged flag); i_cfg writes tolerance (index 0) and iteration cap
// (index 1) and is always ready. Write configuration only while idle.
//
// Each iteration is run on one shared 32x32 multiplier under a sequencer:
// range reduction, fold, u^2, twelve Taylor terms (each a term product,
// reciprocal division and remainder check), e*sin, then update and
// convergence check. i_in is ready only while the sequencer is idle.
//
// The finished result sits in an output register, so the next item is
// accepted while o_out stalls; a second finished result waits in the
// sequencer until the output register frees up. Reset (synchronous,
// active low) empties the output and loads tolerance 268, cap 1000.
module kepler_equation_solver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kes_in_if.sink    i_in,
    kes_out_if.source o_out,
    kes_cfg_if.sink   i_cfg
);
    import kes_pkg::*;

    // Control state
    t_kes_state r_state, n_state;
    t_kes_state r_ret,   n_ret;
    t_pp        r_pp,    n_pp;
    t_term      r_k,     n_k;
    logic       r_ovalid, n_ovalid;
    t_tol       r_tol,   n_tol;
    t_count     r_cap,   n_cap;

    // Item and iteration datapath
    t_angle r_m,    n_m;
    t_ecc   r_ecc,  n_ecc;
    t_angle r_e,    n_e;
    t_angle r_e1,   n_e1;
    t_count r_iter, n_iter;
    logic   r_nc,   n_nc;
    t_red   r_r,    n_r;
    t_word  r_u,    n_u;
    logic   r_sg,   n_sg;

    // Taylor series
    t_word r_u2,  n_u2;
    t_word r_t,   n_t;
    t_word r_sum, n_sum;
    t_word r_x,   n_x;
    t_word r_q,   n_q;

    // Shared multiplier
    t_word r_ma,   n_ma;
    t_word r_mb,   n_mb;
    t_word r_prod, n_prod;
    t_acc  r_acc,  n_acc;

    // Output register
    t_angle r_out_e,  n_out_e;
    t_count r_out_n,  n_out_n;
    logic   r_out_nc, n_out_nc;

    // Combinational helpers
    logic [HALF_WIDTH-1:0] mul_a, mul_b;
    logic [WORD_WIDTH-1:0] mul_out;
    t_acc                  acc_add;
    logic [RED_WIDTH-1:0]  red_abs;
    t_word                 red_u;
    t_word                 fold_u;
    logic                  fold_flip;
    logic [HALF_WIDTH-1:0] rem;
    logic [HALF_WIDTH-1:0] div_ext;
    t_word                 term_fixed;
    t_word                 sum_next;
    logic [ANGLE_WIDTH-1:0] prod_p;
    t_red                  upd_m;
    t_red                  upd_p;
    t_red                  upd_v;
    t_angle                upd_sat;
    logic signed [DIFF_WIDTH-1:0] diff;
    logic [DIFF_WIDTH-1:0] diff_abs;
    t_count                iter_inc;
    t_count                cap_eff;
    logic                  cap_hit;
    logic                  finished;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = r_ovalid;
    assign o_out.eccentric_anomaly = r_out_e;
    assign o_out.iterations_done   = r_out_n;
    assign o_out.not_converged     = r_out_nc;

    // Partial product select and the single multiplier
    always_comb begin
        case (r_pp[1:0])
            2'd0: begin
                mul_a = r_ma[HALF_WIDTH-1:0];
                mul_b = r_mb[HALF_WIDTH-1:0];
            end
            2'd1: begin
                mul_a = r_ma[HALF_WIDTH-1:0];
                mul_b = r_mb[WORD_WIDTH-1:HALF_WIDTH];
            end
            2'd2: begin
                mul_a = r_ma[WORD_WIDTH-1:HALF_WIDTH];
                mul_b = r_mb[HALF_WIDTH-1:0];
            end
            default: begin
                mul_a = r_ma[WORD_WIDTH-1:HALF_WIDTH];
                mul_b = r_mb[WORD_WIDTH-1:HALF_WIDTH];
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // Align the previous partial product by its weight
    always_comb begin
        case (r_pp) inside
            3'd1:       acc_add = {{WORD_WIDTH{1'b0}}, r_prod};
            3'd2, 3'd3: acc_add = {{HALF_WIDTH{1'b0}}, r_prod, {HALF_WIDTH{1'b0}}};
            default:    acc_add = {r_prod, {WORD_WIDTH{1'b0}}};
        endcase
    end

    // Reduced angle magnitude, moved to Q.60
    assign red_abs = r_r[RED_WIDTH-1] ? RED_WIDTH'(-r_r) : RED_WIDTH'(r_r);
    assign red_u   = WORD_WIDTH'(red_abs) << FRAC_SHIFT;

    // Fold into [0, pi/2]
    always_comb begin
        fold_flip = 1'b0;
        if (r_u > PI_FIX) begin
            fold_u    = r_u - PI_FIX;
            fold_flip = 1'b1;
        end else if (r_u > PI_HALF) begin
            fold_u = PI_FIX - r_u;
        end else begin
            fold_u = r_u;
        end
    end

    // Quotient fix-up: the reciprocal estimate is low by at most one
    assign div_ext    = HALF_WIDTH'(TAYLOR_DIV[r_k]);
    assign rem        = r_x[HALF_WIDTH-1:0] - r_acc[HALF_WIDTH-1:0];
    assign term_fixed = (rem >= div_ext) ? r_q + t_word'(1) : r_q;

    // Alternate signs; the subtraction clamps at zero
    always_comb begin
        if (!r_k[0]) begin
            sum_next = (r_sum >= r_t) ? r_sum - r_t : '0;
        end else begin
            sum_next = r_sum + r_t;
        end
    end

    // M +/- e*sin(E), saturated to the angle range
    assign prod_p = r_acc[ECC_SHIFT +: ANGLE_WIDTH];
    assign upd_m  = t_red'(r_m);
    assign upd_p  = $signed({{(RED_WIDTH-ANGLE_WIDTH){1'b0}}, prod_p});
    assign upd_v  = r_sg ? upd_m - upd_p : upd_m + upd_p;

    always_comb begin
        if (upd_v > RED_ANG_MAX) begin
            upd_sat = t_angle'(RED_ANG_MAX);
        end else if (upd_v < RED_ANG_MIN) begin
            upd_sat = t_angle'(RED_ANG_MIN);
        end else begin
            upd_sat = t_angle'(upd_v);
        end
    end

    // Convergence test
    assign diff     = DIFF_WIDTH'(r_e1) - DIFF_WIDTH'(r_e);
    assign diff_abs = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
    assign iter_inc = r_iter + t_count'(1);
    assign cap_eff  = (r_cap == '0) ? t_count'(1) : r_cap;
    assign cap_hit  = (iter_inc >= cap_eff);
    assign finished = (diff_abs <= DIFF_WIDTH'(r_tol)) || cap_hit;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_pp     = r_pp;
        n_k      = r_k;
        n_ovalid = r_ovalid && !o_out.ready;
        n_tol    = r_tol;
        n_cap    = r_cap;
        n_m      = r_m;
        n_ecc    = r_ecc;
        n_e      = r_e;
        n_e1     = r_e1;
        n_iter   = r_iter;
        n_nc     = r_nc;
        n_r      = r_r;
        n_u      = r_u;
        n_sg     = r_sg;
        n_u2     = r_u2;
        n_t      = r_t;
        n_sum    = r_sum;
        n_x      = r_x;
        n_q      = r_q;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_out_e  = r_out_e;
        n_out_n  = r_out_n;
        n_out_nc = r_out_nc;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TOLERANCE:     n_tol = i_cfg.data[TOL_WIDTH-1:0];
                CFG_ITERATION_CAP: n_cap = i_cfg.data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_m     = i_in.mean_anomaly;
                    n_ecc   = i_in.eccentricity;
                    n_e     = i_in.mean_anomaly;
                    n_r     = t_red'(i_in.mean_anomaly);
                    n_iter  = '0;
                    n_state = S_REDUCE;
                end
            end

            S_REDUCE: begin
                // Step by 2*pi until r sits in [-pi, pi)
                if (r_r >= RED_HIGH) begin
                    n_r = r_r - RED_TWO_PI;
                end else if (r_r < RED_LOW) begin
                    n_r = r_r + RED_TWO_PI;
                end else begin
                    n_sg    = r_r[RED_WIDTH-1];
                    n_u     = red_u;
                    n_state = S_FOLD;
                end
            end

            S_FOLD: begin
                n_sg    = r_sg ^ fold_flip;
                n_t     = fold_u;
                n_sum   = fold_u;
                n_k     = '0;
                n_ma    = fold_u;
                n_mb    = fold_u;
                n_acc   = RND_Q60;
                n_pp    = '0;
                n_ret   = S_SQUARE_DONE;
                n_state = S_MUL;
            end

            S_MUL: begin
                n_prod = mul_out;
                if (r_pp != '0) begin
                    n_acc = r_acc + acc_add;
                end
                n_pp = r_pp + t_pp'(1);
                if (r_pp == PP_DRAIN) begin
                    n_state = r_ret;
                end
            end

            S_SQUARE_DONE: begin
                // Hold u^2, start t * u^2 for the first term
                n_u2    = r_acc[INT_FRAC +: WORD_WIDTH];
                n_ma    = r_t;
                n_mb    = r_acc[INT_FRAC +: WORD_WIDTH];
                n_acc   = RND_Q60;
                n_pp    = '0;
                n_ret   = S_TERM_DIV;
                n_state = S_MUL;
            end

            S_TERM_DIV: begin
                // Divide by the constant through its reciprocal
                n_x     = r_acc[INT_FRAC +: WORD_WIDTH];
                n_ma    = r_acc[INT_FRAC +: WORD_WIDTH];
                n_mb    = TAYLOR_RECIP[r_k];
                n_acc   = '0;
                n_pp    = '0;
                n_ret   = S_TERM_REM;
                n_state = S_MUL;
            end

            S_TERM_REM: begin
                n_q     = r_acc[ACC_WIDTH-1:WORD_WIDTH];
                n_ma    = r_acc[ACC_WIDTH-1:WORD_WIDTH];
                n_mb    = WORD_WIDTH'(TAYLOR_DIV[r_k]);
                n_acc   = '0;
                n_pp    = '0;
                n_ret   = S_TERM_FIX;
                n_state = S_MUL;
            end

            S_TERM_FIX: begin
                n_t     = term_fixed;
                n_state = S_TERM_ACC;
            end

            S_TERM_ACC: begin
                n_sum = sum_next;
                n_pp  = '0;
                if (r_k == t_term'(TAYLOR_TERMS - 1)) begin
                    n_ma  = WORD_WIDTH'(r_ecc);
                    n_mb  = sum_next;
                    n_acc = RND_ECC;
                    n_ret = S_UPDATE;
                end else begin
                    n_k   = r_k + t_term'(1);
                    n_ma  = r_t;
                    n_mb  = r_u2;
                    n_acc = RND_Q60;
                    n_ret = S_TERM_DIV;
                end
                n_state = S_MUL;
            end

            S_UPDATE: begin
                n_e1    = upd_sat;
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_e    = r_e1;
                n_iter = iter_inc;
                if (finished) begin
                    n_nc    = cap_hit;
                    n_state = S_DONE;
                end else begin
                    n_r     = t_red'(r_e1);
                    n_state = S_REDUCE;
                end
            end

            S_DONE: begin
                // Wait for the output register to free up
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_out_e  = r_e;
                    n_out_n  = r_iter;
                    n_out_nc = r_nc;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tol    <= TOL_RESET;
            r_cap    <= CAP_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_tol    <= n_tol;
            r_cap    <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_pp     <= n_pp;
        r_k      <= n_k;
        r_m      <= n_m;
        r_ecc    <= n_ecc;
        r_e      <= n_e;
        r_e1     <= n_e1;
        r_iter   <= n_iter;
        r_nc     <= n_nc;
        r_r      <= n_r;
        r_u      <= n_u;
        r_sg     <= n_sg;
        r_u2     <= n_u2;
        r_t      <= n_t;
        r_sum    <= n_sum;
        r_x      <= n_x;
        r_q      <= n_q;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_out_e  <= n_out_e;
        r_out_n  <= n_out_n;
        r_out_nc <= n_out_nc;
    end

endmodule

[verif/kepler_equation_solver_checker.sv]
`timescale 1ns / 1ps

module kepler_equation_solver_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    kes_in_if    i_in,
    kes_out_if   i_out,
    kes_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);
    import kes_pkg::*;

    localparam int          Q60         = 60;
    localparam int          ANGLE_SHIFT = Q60 - ANGLE_FRAC_BITS;
    localparam int          SINE_TERMS  = 12;
    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_ANG      =
        (PI_Q60 + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
    localparam logic [63:0] TWO_PI_ANG  =
        ((PI_Q60 << 1) + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
    localparam longint      ANGLE_MAX   = (64'sd1 <<< (ANGLE_WIDTH - 1)) - 1;
    localparam longint      ANGLE_MIN   = -ANGLE_MAX - 1;

    typedef struct packed {
        t_angle anomaly;
        t_count iterations;
        logic   capped;
    } t_solution;

    t_tol      tolerance_q;
    t_count    cap_q;
    t_solution expected_solutions[$];
    int        mismatch_count = 0;

    // (a * b + half) >> shift over the full 128-bit product
    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int shift);
        logic [127:0] full;
        full = a;
        full = full * b;
        full = full + (128'd1 << (shift - 1));
        return 64'(full >> shift);
    endfunction

    // Sine of an angle-format value: {sign, magnitude in Q.60}
    function automatic logic [64:0] sine_q60(input longint angle);
        longint      pi_a;
        longint      two_pi_a;
        longint      num;
        longint      turns;
        longint      rem;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        neg;
        pi_a     = longint'(PI_ANG);
        two_pi_a = longint'(TWO_PI_ANG);
        num      = angle + pi_a;
        turns    = num / two_pi_a;
        if (num % two_pi_a != 0 && num < 0) begin
            turns = turns - 1;
        end
        rem = angle - turns * two_pi_a;
        neg = rem < 0;
        u   = 64'(neg ? -rem : rem) << ANGLE_SHIFT;
        // fold into [0, pi/2]
        if (u > PI_Q60) begin
            u   = u - PI_Q60;
            neg = !neg;
        end else if (u > (PI_Q60 >> 1)) begin
            u = PI_Q60 - u;
        end
        u2   = mul_round(u, u, Q60);
        term = u;
        sum  = u;
        for (int k = 1; k <= SINE_TERMS; k++) begin
            term = mul_round(term, u2, Q60) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return {neg, sum};
    endfunction

    function automatic longint next_anomaly(input longint mean, input logic [63:0] ecc,
                                            input longint angle);
        logic [64:0] sine;
        longint      prod;
        longint      sum;
        sine = sine_q60(angle);
        prod = longint'(mul_round(ecc, sine[63:0], ECC_WIDTH + Q60 - ANGLE_FRAC_BITS));
        sum  = sine[64] ? mean - prod : mean + prod;
        if (sum > ANGLE_MAX) begin
            return ANGLE_MAX;
        end
        if (sum < ANGLE_MIN) begin
            return ANGLE_MIN;
        end
        return sum;
    endfunction

    function automatic t_solution solve_kepler(input t_angle mean, input t_ecc ecc);
        longint      m;
        longint      est;
        longint      nxt;
        longint      step;
        int unsigned cap;
        int unsigned n;
        t_solution   sol;
        m   = longint'(mean);
        cap = (cap_q == 0) ? 1 : cap_q;
        est = m;
        n   = 0;
        do begin
            nxt  = next_anomaly(m, 64'(ecc), est);
            step = nxt - est;
            if (step < 0) begin
                step = -step;
            end
            est = nxt;
            n++;
        end while (step > longint'(tolerance_q) && n < cap);
        sol.anomaly    = t_angle'(est);
        sol.iterations = t_count'(n);
        sol.capped     = (n >= cap);
        return sol;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_solution want;
        if (!i_rst_n) begin
            tolerance_q = 16'd268;
            cap_q       = 10'd1000;
            expected_solutions.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_TOLERANCE: begin
                        tolerance_q = t_tol'(i_cfg.data);
                    end
                    CFG_ITERATION_CAP: begin
                        cap_q = t_count'(i_cfg.data);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_solutions.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, got %0d",
                             $time, $signed(i_out.eccentric_anomaly));
                end else begin
                    want = expected_solutions.pop_front();
                    if (i_out.eccentric_anomaly !== want.anomaly) begin
                        flag_mismatch("eccentric_anomaly", longint'($signed(want.anomaly)),
                                      longint'($signed(i_out.eccentric_anomaly)));
                    end
                    if (i_out.iterations_done !== want.iterations) begin
                        flag_mismatch("iterations_done", longint'(want.iterations),
                                      longint'(i_out.iterations_done));
                    end
                    if (i_out.not_converged !== want.capped) begin
                        flag_mismatch("not_converged", longint'(want.capped),
                                      longint'(i_out.not_converged));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_solutions.push_back(solve_kepler(i_in.mean_anomaly,
                                                          i_in.eccentricity));
            end
        end
        o_pending    = expected_solutions.size();
        o_mismatches = mismatch_count;
    end

endmodule

[verif/kepler_equation_solver_tb.sv]
`timescale 1ns / 1ps

module kepler_equation_solver_tb;
    import kes_pkg::*;

    // Random phases keep the cap at 24 or less.
    localparam int          LIMIT_CYCLES   = 4_000_000;
    localparam int          SETTLE_CYCLES  = 1000;
    localparam int          PRESSURE_HOLD  = 4000;
    localparam int          RANDOM_CAP_MAX = 24;
    localparam int          BLOCK_ITEMS    = 12;
    localparam int          PI_ANGLE       = 32'h3243F6A9;
    localparam t_cfg_index  CFG_SPARE_LOW  = t_cfg_index'(2);
    localparam t_cfg_index  CFG_SPARE_TOP  = t_cfg_index'(15);

    logic        i_clk;
    logic        i_rst_n;
    int          mismatches;
    int          pending;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          hold_left = 0;

    kes_in_if  in_ch ();
    kes_out_if out_ch ();
    kes_cfg_if cfg_ch ();

    kepler_equation_solver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Watch all three channels, predict each result and compare.
    kepler_equation_solver_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles and give up at the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("kepler_equation_solver regression: fail");
        $finish;
    end

    // Result side: stall at random, or hold off for a counted stretch when asked.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one item after a random gap; return once it is accepted.
    // Leave valid high: the next call either replaces the item or drops valid.
    task automatic offer_item(input t_angle angle, input t_ecc ecc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mean_anomaly <= angle;
        in_ch.eccentricity <= ecc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic await_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index index, input t_cfg_data data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers change only while the block is idle.
    task automatic reconfigure(input t_cfg_data tolerance, input t_cfg_data cap);
        await_results();
        write_register(CFG_TOLERANCE, tolerance);
        write_register(CFG_ITERATION_CAP, cap);
    endtask

    // Mostly full-range angles, some within one turn around zero.
    function automatic t_angle random_anomaly();
        if ($urandom_range(99) < 70) begin
            return t_angle'($urandom);
        end
        return t_angle'(int'($urandom_range(2 * PI_ANGLE)) - PI_ANGLE);
    endfunction

    // Mix full-range, small (fast convergence) and near-one eccentricities.
    function automatic t_ecc random_eccentricity();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return t_ecc'($urandom);
        end
        if (pick < 80) begin
            return t_ecc'($urandom_range(32'h2000_0000));
        end
        return t_ecc'(31'h7FFF_FFFF - $urandom_range(16'hFFFF));
    endfunction

    task automatic random_block(input int count);
        reconfigure(t_cfg_data'($urandom_range(16'hFFFF)),
                    t_cfg_data'($urandom_range(RANDOM_CAP_MAX, 1)));
        repeat (count) offer_item(random_anomaly(), random_eccentricity());
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.mean_anomaly = '0;
        in_ch.eccentricity = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_TOLERANCE;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        send_idle_pct      = 34;
        recv_idle_pct      = 46;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: tolerance 268, cap 1000. Keep eccentricity at most
        // one half here so every item converges long before the cap.
        offer_item(32'sh0000_0000, 31'h0000_0000);
        offer_item(32'sh7FFF_FFFF, 31'h0000_0000);
        offer_item(32'sh8000_0000, 31'h0000_0000);
        offer_item(32'sh3243_F6A9, 31'h4000_0000);
        offer_item(-32'sh1921_FB54, 31'h2000_0000);
        offer_item(32'sh1000_0000, 31'h0CCC_CCCD);
        offer_item(-32'sh1000_0000, 31'h3FFF_FFFF);

        // Zero tolerance, cap of zero (acts as one). Writes to indexes past
        // the register list must change nothing.
        reconfigure(16'd0, 16'd0);
        write_register(CFG_SPARE_LOW, 16'hFFFF);
        write_register(CFG_SPARE_TOP, 16'h0001);
        // Saturate high and low: near-one eccentricity at the angle extremes.
        offer_item(32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        offer_item(32'sh8000_0000, 31'h7FFF_FFFF);
        // Converges on the first pass, which is also the last allowed one.
        offer_item(32'sh0000_0000, 31'h0000_0000);
        offer_item(32'sh5555_5555, 31'h2AAA_AAAA);
        offer_item(32'shAAAA_AAAA, 31'h5555_5555);

        // Widest tolerance; cap written with upper bits set, so it reads 7.
        reconfigure(16'hFFFF, 16'hFC07);
        offer_item(32'sh0C90_FDAA, 31'h7FFF_FFFF);
        offer_item(32'sh4000_0000, 31'h7FFF_FFF0);
        offer_item(-32'sh2000_0000, 31'h6000_0000);
        offer_item(32'sh7FFF_FFFF, 31'h7FFF_FFFF);

        // Largest cap; small eccentricities keep the iteration count short.
        reconfigure(16'd1000, 16'h03FF);
        offer_item(32'sh1234_5678, 31'h0100_0000);
        offer_item(-32'sh1234_5678, 31'h1000_0000);
        offer_item(32'sh3000_0000, 31'h0000_0000);

        // Random items, sender idle 34 and receiver idle 46 of a hundred.
        random_block(BLOCK_ITEMS);
        random_block(BLOCK_ITEMS);

        // Swap the idle rates.
        send_idle_pct = 46;
        recv_idle_pct = 34;
        random_block(BLOCK_ITEMS);
        random_block(BLOCK_ITEMS);

        // Hold the result side off for a long stretch while items keep
        // coming, so the output register and the sequencer both fill and
        // the input stalls. A cap of two keeps each item short.
        reconfigure(t_cfg_data'($urandom_range(16'hFFFF)), 16'd2);
        hold_left = PRESSURE_HOLD;
        repeat (6) offer_item(random_anomaly(), random_eccentricity());

        // No idling at all.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_block(BLOCK_ITEMS);
        random_block(BLOCK_ITEMS / 2);
        // Pause the sender until everything is back, then carry on.
        await_results();
        repeat (BLOCK_ITEMS / 2) offer_item(random_anomaly(), random_eccentricity());

        await_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("kepler_equation_solver regression: pass");
        end else begin
            $display("kepler_equation_solver regression: fail");
        end
        $finish;
    end

endmodule
